// File: src/tlfs_pkg.sv
// Shared types and constants of the two-level feedback scheduler.
`default_nettype none
package tlfs_pkg;
	localparam int L1_DEPTH = 16;
	localparam int L2_DEPTH = 16;
	localparam int L1_AW = $clog2(L1_DEPTH);
	localparam int L2_AW = $clog2(L2_DEPTH);
	localparam int L1_CW = $clog2(L1_DEPTH + 1);
	localparam int L2_CW = $clog2(L2_DEPTH + 1);

	localparam logic [7:0] QUANTUM_RESET = 8'd2;

	localparam logic OP_ADMIT = 1'b0;
	localparam logic OP_RUN   = 1'b1;

	localparam logic [2:0] ST_ADMITTED = 3'd0;
	localparam logic [2:0] ST_DROPPED  = 3'd1;
	localparam logic [2:0] ST_RAN_L1   = 3'd2;
	localparam logic [2:0] ST_RAN_L2   = 3'd3;
	localparam logic [2:0] ST_IDLE     = 3'd4;

	// one level-one table entry
	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  pri;
		logic [15:0] tim;
	} l1_entry_t;

	// one level-two FIFO entry
	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] tim;
	} l2_entry_t;

	// memory write request
	typedef struct packed {
		logic            we;
		logic [L1_AW-1:0] addr;
		l1_entry_t       data;
	} l1_wr_t;
endpackage
`default_nettype wire

// File: src/tlfs_l1_mem.sv
// Level-one table storage: one write port, one registered read port.
`default_nettype none
module tlfs_l1_mem (
	input  wire logic                      clk,
	input  wire tlfs_pkg::l1_wr_t          wr,
	input  wire logic [tlfs_pkg::L1_AW-1:0] raddr,
	output tlfs_pkg::l1_entry_t            rdata
);
	tlfs_pkg::l1_entry_t mem [tlfs_pkg::L1_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: src/tlfs_l2_mem.sv
// Level-two FIFO storage: one write port, one registered read port.
`default_nettype none
module tlfs_l2_mem (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [tlfs_pkg::L2_AW-1:0] waddr,
	input  wire tlfs_pkg::l2_entry_t       wdata,
	input  wire logic [tlfs_pkg::L2_AW-1:0] raddr,
	output tlfs_pkg::l2_entry_t            rdata
);
	tlfs_pkg::l2_entry_t mem [tlfs_pkg::L2_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: src/two_level_feedback_scheduler_unit.sv
// Top level of the two-level feedback scheduler.
//
// Usage:
//  - Command channel: raise start with op/task_* while busy is low; the word
//    is taken at that edge and busy rises the next cycle.
//  - Result: status/served_id/time_left/completed/lost hold for exactly one
//    cycle with done high. The receiver cannot stall; it must take it.
//  - Config: cfg_valid/cfg_ready/cfg_data write the quantum register; ready is
//    high whenever the block is not busy.
//  - Sequencing: admit or idle puts done up the cycle right after the
//    accepting edge; the next word can go in once S_DONE returns to S_IDLE.
//    A level-one run scans the table one entry per cycle through the single
//    read port, then closes the gap by moving each later entry down one slot
//    (read in S_SHIFT, then write in S_SHWR), then serves. A level-two run
//    reads the head entry in S_L2RD, then serves.
//  - Busy covers the result cycle, so one word is in flight at a time.
//  - Reset (arst_n low) empties both levels and sets the quantum to 2;
//    table contents are not cleared, only the counts.
`default_nettype none
module two_level_feedback_scheduler_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [7:0]  task_id,
	input  wire logic [7:0]  task_priority,
	input  wire logic [15:0] task_time,
	output logic             done,
	output logic [2:0]       status,
	output logic [7:0]       served_id,
	output logic [15:0]      time_left,
	output logic             completed,
	output logic             lost,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);
	localparam int AW1 = tlfs_pkg::L1_AW;
	localparam int AW2 = tlfs_pkg::L2_AW;
	localparam int CW1 = tlfs_pkg::L1_CW;
	localparam int CW2 = tlfs_pkg::L2_CW;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_SHIFT = 7'b0000100,
		S_L2RD  = 7'b0001000,
		S_SERVE = 7'b0010000,
		S_DONE  = 7'b0100000,
		S_SHWR  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [7:0] quantum_q;
	logic [CW1-1:0] l1_cnt_q;
	logic [CW2-1:0] l2_cnt_q;
	logic [AW2-1:0] l2_head_q;
	logic [CW1-1:0] idx_q;       // next scan read address
	logic [AW1-1:0] best_q;
	logic [7:0] best_pri_q;
	logic [7:0] best_id_q;
	logic [15:0] best_tim_q;
	logic scan_first_q;
	logic [AW1-1:0] rd_idx_q;    // address of word now on rdata
	logic from_l2_q;

	tlfs_pkg::l1_wr_t l1_wr;
	logic [AW1-1:0] l1_raddr;
	tlfs_pkg::l1_entry_t l1_rdata;
	logic l2_we;
	logic [AW2-1:0] l2_waddr;
	tlfs_pkg::l2_entry_t l2_wdata;
	tlfs_pkg::l2_entry_t l2_rdata;

	tlfs_l1_mem u_l1 (.clk(clk), .wr(l1_wr), .raddr(l1_raddr), .rdata(l1_rdata));
	tlfs_l2_mem u_l2 (.clk(clk), .we(l2_we), .waddr(l2_waddr), .wdata(l2_wdata),
		.raddr(l2_head_q), .rdata(l2_rdata));

	logic accept;
	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = !busy;

	// served task arithmetic
	logic [15:0] srv_tim;
	logic [7:0]  srv_id;
	logic        fin;
	logic [15:0] rem;
	logic        l2_full_srv;
	assign srv_tim = from_l2_q ? l2_rdata.tim : best_tim_q;
	assign srv_id  = from_l2_q ? l2_rdata.id : best_id_q;
	assign fin = srv_tim <= {8'd0, quantum_q};
	assign rem = srv_tim - {8'd0, quantum_q};
	// l2 count already decremented for an l2 serve
	assign l2_full_srv = (l2_cnt_q == CW2'(tlfs_pkg::L2_DEPTH));

	logic [AW2-1:0] l2_tail;
	assign l2_tail = AW2'(l2_head_q + AW2'(l2_cnt_q));

	always_comb begin
		l1_raddr = idx_q[AW1-1:0];
		l1_wr = '0;
		l2_we = 1'b0;
		l2_waddr = l2_tail;
		l2_wdata = '{id: srv_id, tim: rem};
		if (state_q == S_SHIFT) begin
			// fetch the entry just above the gap
			l1_raddr = AW1'(best_q + AW1'(1));
		end
		if (state_q == S_IDLE && accept && op == tlfs_pkg::OP_ADMIT
			&& l1_cnt_q < CW1'(tlfs_pkg::L1_DEPTH)) begin
			l1_wr.we = 1'b1;
			l1_wr.addr = l1_cnt_q[AW1-1:0];
			l1_wr.data = '{id: task_id, pri: task_priority, tim: task_time};
		end
		if (state_q == S_SHWR) begin
			l1_wr.we = 1'b1;
			l1_wr.addr = AW1'(rd_idx_q - AW1'(1));
			l1_wr.data = l1_rdata;
		end
		if (state_q == S_SERVE && !fin && !l2_full_srv) begin
			l2_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			quantum_q <= tlfs_pkg::QUANTUM_RESET;
			l1_cnt_q <= '0;
			l2_cnt_q <= '0;
			l2_head_q <= '0;
			done <= 1'b0;
			status <= '0;
			served_id <= '0;
			time_left <= '0;
			completed <= 1'b0;
			lost <= 1'b0;
			idx_q <= '0;
			scan_first_q <= 1'b0;
			from_l2_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				quantum_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						served_id <= '0;
						time_left <= '0;
						completed <= 1'b0;
						lost <= 1'b0;
						if (op == tlfs_pkg::OP_ADMIT) begin
							if (l1_cnt_q < CW1'(tlfs_pkg::L1_DEPTH)) begin
								l1_cnt_q <= l1_cnt_q + CW1'(1);
								status <= tlfs_pkg::ST_ADMITTED;
							end else begin
								status <= tlfs_pkg::ST_DROPPED;
							end
							done <= 1'b1;
							state_q <= S_DONE;
						end else if (l1_cnt_q != '0) begin
							idx_q <= '0;
							scan_first_q <= 1'b1;
							from_l2_q <= 1'b0;
							state_q <= S_SCAN;
						end else if (l2_cnt_q != '0) begin
							from_l2_q <= 1'b1;
							state_q <= S_L2RD;
						end else begin
							status <= tlfs_pkg::ST_IDLE;
							done <= 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					// rdata holds entry idx_q-1 except on first cycle
					if (!scan_first_q && (idx_q == CW1'(1) || l1_rdata.pri > best_pri_q)) begin
						best_q <= AW1'(idx_q - CW1'(1));
						best_pri_q <= l1_rdata.pri;
						best_id_q <= l1_rdata.id;
						best_tim_q <= l1_rdata.tim;
					end
					scan_first_q <= 1'b0;
					if (!scan_first_q && idx_q == l1_cnt_q) begin
						state_q <= S_SHIFT;
					end else begin
						idx_q <= idx_q + CW1'(1);
					end
				end
				S_SHIFT: begin
					// read entry best+1.., write it one lower
					if (CW1'(best_q) + CW1'(1) >= l1_cnt_q) begin
						l1_cnt_q <= l1_cnt_q - CW1'(1);
						state_q <= S_SERVE;
					end else begin
						idx_q <= CW1'(best_q) + CW1'(1);
						rd_idx_q <= AW1'(CW1'(best_q) + CW1'(1));
						best_q <= AW1'(CW1'(best_q) + CW1'(1));
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					state_q <= S_SHIFT;
				end
				S_L2RD: begin
					l2_head_q <= AW2'(l2_head_q + AW2'(1));
					l2_cnt_q <= l2_cnt_q - CW2'(1);
					state_q <= S_SERVE;
				end
				S_SERVE: begin
					status <= from_l2_q ? tlfs_pkg::ST_RAN_L2 : tlfs_pkg::ST_RAN_L1;
					served_id <= srv_id;
					completed <= fin;
					time_left <= fin ? 16'd0 : rem;
					lost <= !fin && l2_full_srv;
					if (!fin && !l2_full_srv) begin
						l2_cnt_q <= l2_cnt_q + CW2'(1);
					end
					done <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_l1_bound: assert property (@(posedge clk) disable iff (!arst_n)
		l1_cnt_q <= CW1'(tlfs_pkg::L1_DEPTH)) else $error("level one count overflow");
	a_l2_bound: assert property (@(posedge clk) disable iff (!arst_n)
		l2_cnt_q <= CW2'(tlfs_pkg::L2_DEPTH)) else $error("level two count overflow");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result outside busy window");
`endif
endmodule
`default_nettype wire
